@@ rtl/mta_pkg.sv @@
// Shared constants and types for the multi-turn angle accumulator.
`default_nettype none

package mta_pkg;

    // Field widths of the request and result items.
    localparam int ANGLE_W   = 13;
    localparam int DELTA_W   = 14;
    localparam int SUM_W     = 32;
    localparam int ID_W      = 11;
    localparam int SLOT_W    = 2;
    localparam int MASK_W    = 4;

    // Number of receive-ID registers and default number of tracked motors.
    localparam int SLOTS       = 4;
    localparam int MOTORS_DEF  = 4;

    // Encoder turn and half turn in counts.
    localparam int TURN = 8192;
    localparam int HALF = 4096;

    // Stream bus widths, padded to whole bytes.
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 56;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MOTOR0_RX_ID = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOTOR1_RX_ID = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOTOR2_RX_ID = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MOTOR3_RX_ID = 3'd3;

    // Request kinds carried on tuser.
    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic upd;
        logic clr;
    } mta_cmd_t;

endpackage

`default_nettype wire

@@ rtl/mta_ctrl.sv @@
// Controller: stream handshake and result-register occupancy.
`default_nettype none

module mta_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic             s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output mta_pkg::mta_cmd_t     cmd
);
    import mta_pkg::*;

    localparam logic ST_EMPTY = 1'b0;
    localparam logic ST_FULL  = 1'b1;

    logic state_reg;
    logic state_next;
    logic take;

    // A new request is taken when the result register is free or drains now.
    assign s_axis_tready = (state_reg == ST_EMPTY) || m_axis_tready;
    assign take          = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (state_reg == ST_FULL);

    assign cmd.upd = take && (s_axis_tuser == REQ_UPDATE);
    assign cmd.clr = take && (s_axis_tuser == REQ_CLEAR);

    // Next-state logic.
    always_comb
    begin
        case (state_reg)
            ST_EMPTY: state_next = take ? ST_FULL : ST_EMPTY;
            ST_FULL:  state_next = (take || !m_axis_tready) ? ST_FULL : ST_EMPTY;
            default:  state_next = ST_EMPTY;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/mta_datapath.sv @@
// Datapath: per-motor angle state, shortest-step unwrap and result register.
`default_nettype none

module mta_datapath
#(
    parameter int MOTORS = mta_pkg::MOTORS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mta_pkg::mta_cmd_t             cmd,
    input  wire logic [mta_pkg::SLOT_W-1:0]    motor_index,
    input  wire logic [mta_pkg::ANGLE_W-1:0]   raw_angle,
    input  wire logic [mta_pkg::ID_W-1:0]      match_id,
    input  wire logic                          cfg_wr_en,
    input  wire logic [mta_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mta_pkg::ID_W-1:0]      cfg_wdata,
    output logic signed [mta_pkg::DELTA_W-1:0] step_delta,
    output logic signed [mta_pkg::SUM_W-1:0]   turn_sum,
    output logic [mta_pkg::MASK_W-1:0]         cleared_mask
);
    import mta_pkg::*;

    localparam logic signed [DELTA_W-1:0] HALF_D = DELTA_W'(HALF);
    localparam logic signed [DELTA_W-1:0] TURN_D = DELTA_W'(TURN);

    logic [ID_W-1:0]           rx_id_reg [SLOTS];
    logic [ANGLE_W-1:0]        prev_reg  [MOTORS];
    logic signed [SUM_W-1:0]   total_reg [MOTORS];

    logic [ANGLE_W-1:0]        prev_sel;
    logic signed [SUM_W-1:0]   total_sel;
    logic                      slot_ok;
    logic signed [DELTA_W-1:0] diff;
    logic signed [DELTA_W-1:0] step;
    logic signed [SUM_W-1:0]   sum_new;
    logic [MASK_W-1:0]         match_mask;

    logic signed [DELTA_W-1:0] step_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [MASK_W-1:0]         mask_reg;

    // Receive-ID registers; writes beyond the last register are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                rx_id_reg[k] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MOTOR0_RX_ID: rx_id_reg[0] <= cfg_wdata;
                REG_MOTOR1_RX_ID: rx_id_reg[1] <= cfg_wdata;
                REG_MOTOR2_RX_ID: rx_id_reg[2] <= cfg_wdata;
                REG_MOTOR3_RX_ID: rx_id_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Select the addressed motor's state.
    always_comb
    begin
        prev_sel  = '0;
        total_sel = '0;
        slot_ok   = 1'b0;
        for (int k = 0; k < MOTORS; k++)
        begin
            if (motor_index == SLOT_W'(k))
            begin
                prev_sel  = prev_reg[k];
                total_sel = total_reg[k];
                slot_ok   = 1'b1;
            end
        end
    end

    // Shortest step: fold differences beyond half a turn; a half-turn tie keeps d.
    always_comb
    begin
        diff = $signed({1'b0, raw_angle}) - $signed({1'b0, prev_sel});
        if (diff > HALF_D)
        begin
            step = diff - TURN_D;
        end
        else if (diff < -HALF_D)
        begin
            step = diff + TURN_D;
        end
        else
        begin
            step = diff;
        end
        sum_new = total_sel + SUM_W'(step);
    end

    // Slots whose receive ID matches the clear request.
    always_comb
    begin
        match_mask = '0;
        for (int k = 0; k < MOTORS; k++)
        begin
            match_mask[k] = (rx_id_reg[k] == match_id);
        end
    end

    // Motor state update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MOTORS; k++)
            begin
                prev_reg[k]  <= '0;
                total_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < MOTORS; k++)
            begin
                if (cmd.upd && (motor_index == SLOT_W'(k)))
                begin
                    prev_reg[k]  <= raw_angle;
                    total_reg[k] <= sum_new;
                end
                else if (cmd.clr && match_mask[k])
                begin
                    total_reg[k] <= '0;
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.upd)
        begin
            step_reg <= slot_ok ? step : '0;
            sum_reg  <= slot_ok ? sum_new : '0;
            mask_reg <= '0;
        end
        else if (cmd.clr)
        begin
            step_reg <= '0;
            sum_reg  <= '0;
            mask_reg <= match_mask;
        end
    end

    assign step_delta   = step_reg;
    assign turn_sum     = sum_reg;
    assign cleared_mask = mask_reg;

endmodule

`default_nettype wire

@@ rtl/multi_turn_angle_accumulator.sv @@
// Top level of the multi-turn angle accumulator.
//
// Tracks the unwrapped angle of up to MOTORS motors with 13-bit encoders.
// Input stream: tuser selects the request kind (0 = angle update,
// 1 = clear sums by receive ID); tdata carries motor_index, raw_angle and
// match_id. Each request gives exactly one result on the output stream:
// the shortest step and new running sum for an update, or the mask of
// cleared motor slots for a clear.
// A valid result appears in the cycle after a request is accepted. The
// unwrap, compare and 32-bit accumulate complete in the accept cycle, so
// one request per cycle is sustained while the receiver keeps up.
// When the receiver stalls, the single result register holds its value and
// the input is not ready until that result is taken (or in the same cycle).
// Reset clears the receive IDs, previous angles and sums to zero and
// empties the result register. The user writes receive IDs through the
// configuration port only while no request is in flight; the block does not check.
`default_nettype none

module multi_turn_angle_accumulator
#(
    parameter int MOTORS = mta_pkg::MOTORS_DEF
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Input stream.
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: motor_index[1:0], raw_angle[14:2], match_id[25:15], zero pad.
    input  wire logic [mta_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser: req_type.
    input  wire logic                             s_axis_tuser,
    // Output stream.
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // tdata: step_delta[13:0], turn_sum[45:14], cleared_mask[49:46], zero pad.
    output logic [mta_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // Configuration write port.
    input  wire logic                             cfg_wr_en,
    input  wire logic [mta_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mta_pkg::ID_W-1:0]         cfg_wdata
);
    import mta_pkg::*;

    localparam int PAD_W = OUT_DATA_W - DELTA_W - SUM_W - MASK_W;

    mta_cmd_t                  cmd;
    logic signed [DELTA_W-1:0] step_delta;
    logic signed [SUM_W-1:0]   turn_sum;
    logic [MASK_W-1:0]         cleared_mask;

    mta_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd)
    );

    mta_datapath #(.MOTORS(MOTORS)) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .motor_index  (s_axis_tdata[SLOT_W-1:0]),
        .raw_angle    (s_axis_tdata[SLOT_W+ANGLE_W-1:SLOT_W]),
        .match_id     (s_axis_tdata[SLOT_W+ANGLE_W+ID_W-1:SLOT_W+ANGLE_W]),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .step_delta   (step_delta),
        .turn_sum     (turn_sum),
        .cleared_mask (cleared_mask)
    );

    // Pack the result fields, lowest field first.
    assign m_axis_tdata = {{PAD_W{1'b0}}, cleared_mask, turn_sum, step_delta};

endmodule

`default_nettype wire

@@ tb/multi_turn_angle_accumulator_test.sv @@
// Self-checking testbench for the multi-turn angle accumulator with random handshake stalls.
`timescale 1ns / 100ps

import mta_pkg::*;

// One expected result item, fields as they appear on the output stream.
typedef struct {
    logic signed [DELTA_W-1:0] delta;
    logic signed [SUM_W-1:0]   sum;
    logic [MASK_W-1:0]         mask;
} turn_result_t;

// Scoreboard: tracks per-slot angle and sum and queues the result of each request.
class turn_scoreboard;
    localparam int MAX_REPORTS = 10;

    logic [ID_W-1:0]    rx_id[SLOTS];
    logic [ANGLE_W-1:0] last_angle[SLOTS];
    logic [SUM_W-1:0]   total[SLOTS];
    turn_result_t       awaited_turns[$];
    int mismatches;
    int results_seen;
    int updates_seen;
    int clears_seen;
    int settings_seen;

    function new();
        for (int k = 0; k < SLOTS; k++)
        begin
            rx_id[k] = '0;
            last_angle[k] = '0;
            total[k] = '0;
        end
        mismatches = 0;
        results_seen = 0;
        updates_seen = 0;
        clears_seen = 0;
        settings_seen = 1;
    endfunction

    // Register writes beyond the last slot are dropped by the block.
    function void write_rx_id(logic [CFG_IDX_W-1:0] idx, logic [ID_W-1:0] value);
        if (int'(idx) < SLOTS)
            rx_id[idx] = value;
    endfunction

    // Shortest signed step from one encoder reading to the next.
    function logic signed [DELTA_W-1:0] unwrap_step(logic [ANGLE_W-1:0] now_angle,
                                                   logic [ANGLE_W-1:0] prev_angle);
        int d;
        int alt;
        int mag_d;
        int mag_alt;
        d = int'(now_angle) - int'(prev_angle);
        alt = (d > 0) ? d - TURN : d + TURN;
        mag_d = (d < 0) ? -d : d;
        mag_alt = (alt < 0) ? -alt : alt;
        if (mag_alt < mag_d)
            return alt[DELTA_W-1:0];
        return d[DELTA_W-1:0];
    endfunction

    // Predict the result of one accepted request and update the tracked state.
    function void note_request(logic kind, logic [SLOT_W-1:0] slot,
                               logic [ANGLE_W-1:0] angle, logic [ID_W-1:0] id);
        turn_result_t want;
        logic signed [DELTA_W-1:0] step;
        want.delta = '0;
        want.sum = '0;
        want.mask = '0;
        if (kind == REQ_UPDATE)
        begin
            updates_seen++;
            if (int'(slot) < MOTORS_DEF)
            begin
                step = unwrap_step(angle, last_angle[slot]);
                total[slot] = total[slot] + {{(SUM_W-DELTA_W){step[DELTA_W-1]}}, step};
                last_angle[slot] = angle;
                want.delta = step;
                want.sum = total[slot];
            end
        end
        else
        begin
            clears_seen++;
            for (int k = 0; k < MOTORS_DEF; k++)
            begin
                if (rx_id[k] == id)
                begin
                    total[k] = '0;
                    want.mask[k] = 1'b1;
                end
            end
        end
        awaited_turns.push_back(want);
    endfunction

    // Compare one accepted result with the oldest prediction.
    function void check_result(logic [OUT_DATA_W-1:0] data);
        turn_result_t want;
        logic signed [DELTA_W-1:0] got_delta;
        logic signed [SUM_W-1:0]   got_sum;
        logic [MASK_W-1:0]         got_mask;
        got_delta = data[DELTA_W-1:0];
        got_sum = data[DELTA_W +: SUM_W];
        got_mask = data[DELTA_W+SUM_W +: MASK_W];
        results_seen++;
        if (awaited_turns.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("ERROR: result with nothing awaited: delta %0d sum %0d mask %h",
                         got_delta, got_sum, got_mask);
            return;
        end
        want = awaited_turns.pop_front();
        if (got_delta !== want.delta || got_sum !== want.sum || got_mask !== want.mask)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display({"ERROR: result %0d expected delta %0d sum %0d mask %h,",
                          " got delta %0d sum %0d mask %h"},
                         results_seen, want.delta, want.sum, want.mask,
                         got_delta, got_sum, got_mask);
        end
    endfunction
endclass

module multi_turn_angle_accumulator_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int IN_PAD_W = IN_DATA_W - SLOT_W - ANGLE_W - ID_W;
    localparam int DRAIN_CYCLES = 4;

    logic                    clk;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata;
    logic                    s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [ID_W-1:0]         cfg_wdata;

    turn_scoreboard sb;
    bit             calm;
    int             cycles;

    multi_turn_angle_accumulator dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog on the total run length.
    initial
        cycles = 0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Present one request after a random gap, none while calm, and hold it until it is accepted.
    task automatic send_request(input logic kind, input logic [SLOT_W-1:0] slot,
                                input logic [ANGLE_W-1:0] angle, input logic [ID_W-1:0] id);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tuser = kind;
        s_axis_tdata = {{IN_PAD_W{1'b0}}, id, angle, slot};
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(kind, slot, angle, id);
        @(negedge clk);
    endtask

    // Wait until every predicted result has come back and the block is idle.
    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (sb.awaited_turns.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // One configuration register write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ID_W-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        sb.write_rx_id(idx, value);
    endtask

    // Load all four receive IDs plus a stray write past the last register.
    task automatic load_ids(input logic [ID_W-1:0] id0, input logic [ID_W-1:0] id1,
                            input logic [ID_W-1:0] id2, input logic [ID_W-1:0] id3);
        logic [CFG_IDX_W-1:0] stray;
        wait_drained();
        write_reg(REG_MOTOR0_RX_ID, id0);
        write_reg(REG_MOTOR1_RX_ID, id1);
        write_reg(REG_MOTOR2_RX_ID, id2);
        write_reg(REG_MOTOR3_RX_ID, id3);
        stray = REG_MOTOR3_RX_ID + CFG_IDX_W'($urandom_range(1, 4));
        write_reg(stray, ID_W'($urandom_range(0, 2047)));
        sb.settings_seen++;
    endtask

    // Random traffic: mostly encoder walks with a per-slot drift, some clears.
    task automatic run_random(input int count);
        int choice;
        int slot;
        int base;
        int step;
        logic [ID_W-1:0] id;
        logic [ANGLE_W-1:0] angle;
        for (int n = 0; n < count; n++)
        begin
            choice = $urandom_range(0, 99);
            if (choice < 15)
            begin
                if ($urandom_range(0, 3) != 0)
                    id = sb.rx_id[$urandom_range(0, SLOTS-1)];
                else
                    id = ID_W'($urandom_range(0, 2047));
                send_request(REQ_CLEAR, SLOT_W'($urandom_range(0, 3)),
                             ANGLE_W'($urandom_range(0, 8191)), id);
            end
            else
            begin
                slot = $urandom_range(0, SLOTS-1);
                base = int'(sb.last_angle[slot]);
                choice = $urandom_range(0, 9);
                if (choice < 6)
                begin
                    // Drift forward on the low slots and backward on the high ones.
                    step = $urandom_range(0, 3000);
                    if (($urandom_range(0, 3) == 0) ^ (slot >= 2))
                        step = -step;
                    angle = ANGLE_W'(base + step);
                end
                else if (choice < 8)
                    angle = ANGLE_W'(base + HALF + $urandom_range(0, 4) - 2);
                else if (choice == 8)
                    angle = ANGLE_W'(base);
                else
                    angle = ANGLE_W'($urandom_range(0, 8191));
                send_request(REQ_UPDATE, SLOT_W'(slot), angle,
                             ID_W'($urandom_range(0, 2047)));
            end
        end
    endtask

    // Result sink with a random stall before each result, none while calm.
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            sb.check_result(m_axis_tdata);
            @(negedge clk);
        end
    end

    // Main sequence: reset, directed requests, then random phases under several ID settings.
    initial
    begin
        sb = new();
        calm = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = REQ_UPDATE;
        cfg_wr_en = 1'b0;
        cfg_index = REG_MOTOR0_RX_ID;
        cfg_wdata = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Equal angles, wrap across zero both ways and the half-turn tie.
        send_request(REQ_UPDATE, 2'd0, 13'd0, 11'd0);
        send_request(REQ_UPDATE, 2'd0, 13'd8191, 11'd2047);
        send_request(REQ_UPDATE, 2'd0, 13'd0, 11'd0);
        send_request(REQ_UPDATE, 2'd1, 13'd4096, 11'd0);
        send_request(REQ_UPDATE, 2'd1, 13'd0, 11'd0);
        send_request(REQ_UPDATE, 2'd1, 13'd4097, 11'd0);
        send_request(REQ_UPDATE, 2'd1, 13'd1, 11'd0);
        send_request(REQ_UPDATE, 2'd2, 13'd8191, 11'd0);
        send_request(REQ_UPDATE, 2'd2, 13'd8191, 11'd0);
        send_request(REQ_UPDATE, 2'd3, 13'd4095, 11'd0);
        send_request(REQ_UPDATE, 2'd3, 13'd8190, 11'd0);
        send_request(REQ_UPDATE, 2'd3, 13'd1, 11'd0);
        // All IDs are zero after reset, so this clears every slot at once.
        send_request(REQ_CLEAR, 2'd0, 13'd0, 11'd0);
        send_request(REQ_CLEAR, 2'd3, 13'd8191, 11'd2047);
        send_request(REQ_UPDATE, 2'd3, 13'h1555, 11'h555);
        send_request(REQ_UPDATE, 2'd2, 13'h0AAA, 11'h2AA);
        send_request(REQ_CLEAR, 2'd1, 13'h0AAA, 11'h555);

        // Mixed IDs with a shared value, then clears that hit one, several or none.
        load_ids(11'h555, 11'h2AA, 11'h555, 11'h7FF);
        send_request(REQ_UPDATE, 2'd0, 13'd2000, 11'd0);
        send_request(REQ_UPDATE, 2'd1, 13'd6000, 11'd0);
        send_request(REQ_CLEAR, 2'd0, 13'd0, 11'h555);
        send_request(REQ_CLEAR, 2'd0, 13'd0, 11'h2AA);
        send_request(REQ_CLEAR, 2'd0, 13'd0, 11'h7FF);
        send_request(REQ_CLEAR, 2'd0, 13'd0, 11'h000);

        load_ids(11'd2047, 11'd2047, 11'd2047, 11'd2047);
        run_random(100);

        // A stretch with no idling on either side.
        load_ids(11'd5, 11'd5, 11'd2046, 11'd5);
        calm = 1'b1;
        run_random(100);
        wait_drained();
        calm = 1'b0;

        load_ids(ID_W'($urandom_range(0, 2047)), ID_W'($urandom_range(0, 2047)),
                 ID_W'($urandom_range(0, 2047)), ID_W'($urandom_range(0, 2047)));
        run_random(100);

        load_ids(11'd0, 11'd2047, 11'd0, 11'd2047);
        run_random(100);

        load_ids(ID_W'($urandom_range(0, 2047)), ID_W'($urandom_range(0, 7)),
                 ID_W'($urandom_range(0, 7)), ID_W'($urandom_range(2040, 2047)));
        run_random(100);

        wait_drained();
        repeat (8) @(negedge clk);

        $display("Checked %0d results from %0d updates and %0d clears over %0d ID settings.",
                 sb.results_seen, sb.updates_seen, sb.clears_seen, sb.settings_seen);
        $display("Mismatches: %0d, results still awaited: %0d.",
                 sb.mismatches, sb.awaited_turns.size());
        if (sb.mismatches == 0 && sb.awaited_turns.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ multi_turn_angle_accumulator.f @@
rtl/mta_pkg.sv
rtl/mta_ctrl.sv
rtl/mta_datapath.sv
rtl/multi_turn_angle_accumulator.sv
tb/multi_turn_angle_accumulator_test.sv
